[rtl/pbl_pkg.sv]
// pbl_pkg: shared types, command and status codes and arithmetic constants
// for the breathing led controller. No dependencies.
`default_nettype none

package pbl_pkg;

    localparam int FUNC_W   = 3;
    localparam int CHAN_W   = 4;
    localparam int START_W  = 8;
    localparam int LEVEL_W  = 7;
    localparam int DUTY_W   = 16;
    localparam int STATUS_W = 2;

    // level * max_duty fits in 23 bits
    localparam int PROD_W = LEVEL_W + DUTY_W;

    // divide by 100 as a shift by two and a reciprocal multiply by 1/25
    localparam int QUO_W       = PROD_W - 2;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP      = 7'd100;
    localparam logic [DUTY_W-1:0]  MAX_DUTY_RESET = 16'd44444;

    localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_OFF    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ON     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TOGGLE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_START  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CHANNEL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_COMMAND = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [CHAN_W-1:0]  channel;
        logic [START_W-1:0] start_level;
    } t_item;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic                duty_write;
        logic [STATUS_W-1:0] status;
        logic [PROD_W-1:0]   prod;
    } t_mid;

    typedef struct packed {
        logic [CHAN_W-1:0]   out_channel;
        logic                duty_write;
        logic [DUTY_W-1:0]   duty;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

`default_nettype wire

[rtl/pbl_item_if.sv]
// pbl_item_if: valid/ready channel carrying one command item.
// Depends on pbl_pkg for field widths.
`default_nettype none

interface pbl_item_if import pbl_pkg::*;;
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [CHAN_W-1:0]  channel;
    logic [START_W-1:0] start_level;

    modport source (output valid, output func, output channel, output start_level,
                    input ready);
    modport sink   (input valid, input func, input channel, input start_level,
                    output ready);
endinterface

`default_nettype wire

[rtl/pbl_result_if.sv]
// pbl_result_if: valid/ready channel carrying one result item.
// Depends on pbl_pkg for field widths.
`default_nettype none

interface pbl_result_if import pbl_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   out_channel;
    logic                duty_write;
    logic [DUTY_W-1:0]   duty;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output out_channel, output duty_write, output duty,
                    output status, input ready);
    modport sink   (input valid, input out_channel, input duty_write, input duty,
                    input status, output ready);
endinterface

`default_nettype wire

[rtl/pbl_cmd_stage.sv]
// pbl_cmd_stage: per-channel level, direction and enable registers, command
// decode with read-modify-write, and the level * max_duty product.
// Depends on pbl_pkg.
`default_nettype none

module pbl_cmd_stage import pbl_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire t_item             i_item,
    input  wire logic [DUTY_W-1:0] i_max_duty,
    output t_mid                   o_mid
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [LEVEL_W-1:0] r_level [CHANNELS];
    logic [CHANNELS-1:0] r_rising;
    logic [CHANNELS-1:0] r_running;

    logic [IDX_W-1:0]    idx;
    logic                ch_ok;
    logic [LEVEL_W-1:0]  cur_level;
    logic                cur_rising;
    logic                cur_running;
    logic [LEVEL_W-1:0]  n_level;
    logic                n_rising;
    logic                n_running;
    logic                issue;
    logic                write;
    logic [STATUS_W-1:0] status;
    logic [LEVEL_W-1:0]  clamped;

    assign idx   = i_item.channel[IDX_W-1:0];
    assign ch_ok = {1'b0, i_item.channel} < (CHAN_W + 1)'(CHANNELS);

    assign cur_level   = r_level[idx];
    assign cur_rising  = r_rising[idx];
    assign cur_running = r_running[idx];

    assign clamped = (i_item.start_level > START_W'(LEVEL_TOP)) ? LEVEL_TOP
                                                                : i_item.start_level[LEVEL_W-1:0];

    always_comb begin
        n_level   = cur_level;
        n_rising  = cur_rising;
        n_running = cur_running;
        issue     = 1'b0;
        write     = 1'b0;
        status    = ST_OK;
        if (!ch_ok) begin
            status = ST_BAD_CHANNEL;
        end else begin
            case (i_item.func)
                FN_TICK: begin
                    if (cur_running) begin
                        if (cur_rising && cur_level >= LEVEL_TOP) begin
                            n_rising = 1'b0;
                        end else if (!cur_rising && cur_level == '0) begin
                            n_rising = 1'b1;
                        end else begin
                            issue   = 1'b1;
                            write   = 1'b1;
                            n_level = cur_rising ? cur_level + 1'b1 : cur_level - 1'b1;
                        end
                    end
                end
                FN_OFF: begin
                    n_running = 1'b0;
                    write     = 1'b1;
                end
                FN_ON: begin
                    n_running = 1'b1;
                    write     = 1'b1;
                end
                FN_TOGGLE: begin
                    write     = cur_running;
                    n_running = !cur_running;
                end
                FN_START: begin
                    n_running = 1'b1;
                    n_level   = clamped;
                end
                default: begin
                    status = ST_BAD_COMMAND;
                end
            endcase
        end
    end

    always_comb begin
        o_mid.channel    = i_item.channel;
        o_mid.duty_write = write;
        o_mid.status     = status;
        // only a tick that steps the level issues a non-zero duty
        o_mid.prod       = issue ? PROD_W'(cur_level) * PROD_W'(i_max_duty) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_level[i] <= '0;
            end
            r_rising  <= '1;
            r_running <= '0;
        end else if (i_fire && ch_ok) begin
            r_level[idx]   <= n_level;
            r_rising[idx]  <= n_rising;
            r_running[idx] <= n_running;
        end
    end

`ifndef SYNTHESIS
    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && ch_ok |-> cur_level <= LEVEL_TOP)
        else $error("channel level above top");
`endif

endmodule

`default_nettype wire

[rtl/pbl_duty_div.sv]
// pbl_duty_div: floor(prod / 100) by a shift of two and a reciprocal
// multiply for the division by 25. Depends on pbl_pkg.
`default_nettype none

module pbl_duty_div import pbl_pkg::*; (
    input  wire t_mid i_mid,
    output t_result   o_result
);

    logic [QUO_W-1:0]         quarter;
    logic [QUO_W+RECIP_W-1:0] scaled;

    assign quarter = i_mid.prod[PROD_W-1:2];
    // exact for every quarter below 2^21
    assign scaled  = (QUO_W + RECIP_W)'(quarter) * (QUO_W + RECIP_W)'(RECIP_25);

    always_comb begin
        o_result.out_channel = i_mid.channel;
        o_result.duty_write  = i_mid.duty_write;
        o_result.duty        = scaled[RECIP_SHIFT +: DUTY_W];
        o_result.status      = i_mid.status;
    end

endmodule

`default_nettype wire

[rtl/pwm_breathing_led_controller.sv]
// pwm_breathing_led_controller: top level, three-register pipeline.
// An accepted item is loaded into the input register on the acceptance edge, then the
// product and result registers follow, each taking it as soon as it has room.
// Throughput: one item per cycle while o_result.ready is held high.
// A stalled result backs up the pipeline one stage at a time; bubbles fill.
// Reset (synchronous, active low): all stages empty, every channel at level 0,
// rising and stopped, max_duty back to 44444.
// Depends on pbl_pkg, pbl_item_if, pbl_result_if, pbl_cmd_stage, pbl_duty_div.
`default_nettype none

module pwm_breathing_led_controller import pbl_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_max_duty_we,
    input  wire logic [DUTY_W-1:0] i_max_duty_wdata,
    pbl_item_if.sink               i_item,
    pbl_result_if.source           o_result
);

    logic [DUTY_W-1:0] r_max_duty;

    logic    r_a_valid;
    t_item   r_a;
    logic    r_b_valid;
    t_mid    r_b;
    logic    r_c_valid;
    t_result r_c;

    logic    en_a;
    logic    en_b;
    logic    en_c;
    logic    fire;
    t_mid    n_b;
    t_result n_c;

    assign en_c = !r_c_valid || o_result.ready;
    assign en_b = !r_b_valid || en_c;
    assign en_a = !r_a_valid || en_b;
    assign fire = r_a_valid && en_b;

    assign i_item.ready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_duty <= MAX_DUTY_RESET;
        end else begin
            if (i_max_duty_we) begin
                r_max_duty <= i_max_duty_wdata;
            end
        end
    end

    pbl_cmd_stage #(
        .CHANNELS (CHANNELS)
    ) u_cmd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (r_a),
        .i_max_duty (r_max_duty),
        .o_mid      (n_b)
    );

    pbl_duty_div u_div (
        .i_mid    (r_b),
        .o_result (n_c)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_item.valid;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
            if (en_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en_a && i_item.valid) begin
            r_a.func        <= i_item.func;
            r_a.channel     <= i_item.channel;
            r_a.start_level <= i_item.start_level;
        end
        if (fire) begin
            r_b <= n_b;
        end
        if (en_c && r_b_valid) begin
            r_c <= n_c;
        end
    end

    assign o_result.valid       = r_c_valid;
    assign o_result.out_channel = r_c.out_channel;
    assign o_result.duty_write  = r_c.duty_write;
    assign o_result.duty        = r_c.duty;
    assign o_result.status      = r_c.status;

`ifndef SYNTHESIS
    a_error_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && r_c.status != ST_OK |-> !r_c.duty_write)
        else $error("error result issues a duty");

    a_no_write_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && !r_c.duty_write |-> r_c.duty == '0)
        else $error("duty non-zero without a write");

    a_stage_b_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !en_b |=> r_b_valid && $stable(r_b))
        else $error("product stage lost while stalled");
`endif

endmodule

`default_nettype wire

[bench/pwm_breathing_led_controller_test.sv]
// pwm_breathing_led_controller_test: self-checking bench for the breathing led controller.
// Drives command items, expects each result from the directed table or its own per-channel
// level model and checks the results in order. Depends on pbl_pkg, pbl_item_if and pbl_result_if.
`default_nettype none

module pwm_breathing_led_controller_test import pbl_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CHANNELS    = 8;
    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 6;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_AFTER      = 350;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_GAP         = 4;

    // unused command codes
    localparam logic [FUNC_W-1:0] FN_RSVD_A = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD_B = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_C = 3'd7;

    typedef struct packed {
        t_item   cmd;
        logic    typed;
        t_result want;
    } t_row;

    function automatic t_row plain_row(input logic [FUNC_W-1:0] f,
                                       input logic [CHAN_W-1:0] c,
                                       input logic [START_W-1:0] s);
        t_row r;
        r = '0;
        r.cmd.func = f;
        r.cmd.channel = c;
        r.cmd.start_level = s;
        return r;
    endfunction

    function automatic t_row known_row(input logic [FUNC_W-1:0] f,
                                       input logic [CHAN_W-1:0] c,
                                       input logic [START_W-1:0] s,
                                       input logic w,
                                       input logic [DUTY_W-1:0] d,
                                       input logic [STATUS_W-1:0] st);
        t_row r;
        r = plain_row(f, c, s);
        r.typed = 1'b1;
        r.want.out_channel = c;
        r.want.duty_write = w;
        r.want.duty = d;
        r.want.status = st;
        return r;
    endfunction

    localparam int DIRECTED_N = 25;
    localparam t_row DIRECTED [DIRECTED_N] = '{
        known_row(FN_TICK,   4'd0,  8'd0,   1'b0, 16'd0, ST_OK),  // tick on a stopped channel
        known_row(FN_RSVD_A, 4'd0,  8'd0,   1'b0, 16'd0, ST_BAD_COMMAND),
        known_row(FN_RSVD_C, 4'd7,  8'd255, 1'b0, 16'd0, ST_BAD_COMMAND),
        known_row(FN_TICK,   4'd8,  8'd0,   1'b0, 16'd0, ST_BAD_CHANNEL),
        // channel check wins over command check
        known_row(FN_RSVD_C, 4'd15, 8'd0,   1'b0, 16'd0, ST_BAD_CHANNEL),
        known_row(FN_OFF,    4'd1,  8'd0,   1'b1, 16'd0, ST_OK),
        known_row(FN_ON,     4'd1,  8'd0,   1'b1, 16'd0, ST_OK),
        known_row(FN_TOGGLE, 4'd1,  8'd0,   1'b1, 16'd0, ST_OK),  // stops: issues zero
        known_row(FN_TOGGLE, 4'd1,  8'd0,   1'b0, 16'd0, ST_OK),  // starts: nothing issued
        known_row(FN_START,  4'd2,  8'd255, 1'b0, 16'd0, ST_OK),  // clamped to the top
        known_row(FN_TICK,   4'd2,  8'd0,   1'b0, 16'd0, ST_OK),  // turns round at the top
        known_row(FN_TICK,   4'd2,  8'd0,   1'b1, MAX_DUTY_RESET, ST_OK),
        plain_row(FN_TICK,   4'd2,  8'd0),
        known_row(FN_START,  4'd2,  8'd0,   1'b0, 16'd0, ST_OK),  // keeps falling direction
        known_row(FN_TICK,   4'd2,  8'd0,   1'b0, 16'd0, ST_OK),  // turns round at zero
        known_row(FN_TICK,   4'd2,  8'd0,   1'b1, 16'd0, ST_OK),
        plain_row(FN_TICK,   4'd2,  8'd0),
        known_row(FN_START,  4'd7,  8'd101, 1'b0, 16'd0, ST_OK),
        known_row(FN_TICK,   4'd7,  8'd0,   1'b0, 16'd0, ST_OK),
        known_row(FN_TICK,   4'd7,  8'd0,   1'b1, MAX_DUTY_RESET, ST_OK),
        known_row(FN_START,  4'd3,  8'd50,  1'b0, 16'd0, ST_OK),
        plain_row(FN_TICK,   4'd3,  8'd0),
        known_row(FN_TOGGLE, 4'd3,  8'd0,   1'b1, 16'd0, ST_OK),
        known_row(FN_TICK,   4'd3,  8'd0,   1'b0, 16'd0, ST_OK),
        known_row(FN_RSVD_B, 4'd9,  8'd127, 1'b0, 16'd0, ST_BAD_CHANNEL)
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_max_duty_we;
    logic [DUTY_W-1:0] i_max_duty_wdata;

    pbl_item_if   item_ch ();
    pbl_result_if result_ch ();

    pwm_breathing_led_controller #(
        .CHANNELS(NUM_CHANNELS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_max_duty_we   (i_max_duty_we),
        .i_max_duty_wdata(i_max_duty_wdata),
        .i_item          (item_ch),
        .o_result        (result_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // per-channel breathing state as the bench sees it
    logic [LEVEL_W-1:0] ch_level   [NUM_CHANNELS];
    logic               ch_rising  [NUM_CHANNELS];
    logic               ch_running [NUM_CHANNELS];
    logic [DUTY_W-1:0]  duty_scale;

    t_result duty_expect_q [$];
    int      n_errors;
    int      n_results;
    int      stall_cycles;
    bit      send_steady;
    bit      recv_steady;
    logic [DUTY_W-1:0] phase_scale [NUM_PHASES];

    function automatic t_result breathe_step(input t_item it);
        t_result     r;
        int          ch;
        int unsigned prod;
        r = '0;
        r.out_channel = it.channel;
        r.status = ST_OK;
        ch = int'(it.channel);
        if (ch >= NUM_CHANNELS) begin
            r.status = ST_BAD_CHANNEL;
        end else begin
            case (it.func)
                FN_TICK: begin
                    if (ch_running[ch]) begin
                        if (ch_rising[ch] && ch_level[ch] >= LEVEL_TOP) begin
                            ch_rising[ch] = 1'b0;
                        end else if (!ch_rising[ch] && ch_level[ch] == '0) begin
                            ch_rising[ch] = 1'b1;
                        end else begin
                            prod = 32'(ch_level[ch]) * 32'(duty_scale);
                            r.duty_write = 1'b1;
                            r.duty = DUTY_W'(prod / 32'(LEVEL_TOP));
                            if (ch_rising[ch])
                                ch_level[ch] = ch_level[ch] + 1'b1;
                            else
                                ch_level[ch] = ch_level[ch] - 1'b1;
                        end
                    end
                end
                FN_OFF: begin
                    ch_running[ch] = 1'b0;
                    r.duty_write = 1'b1;
                end
                FN_ON: begin
                    ch_running[ch] = 1'b1;
                    r.duty_write = 1'b1;
                end
                FN_TOGGLE: begin
                    r.duty_write = ch_running[ch];
                    ch_running[ch] = !ch_running[ch];
                end
                FN_START: begin
                    ch_running[ch] = 1'b1;
                    ch_level[ch] = (it.start_level > START_W'(LEVEL_TOP)) ?
                                   LEVEL_TOP : it.start_level[LEVEL_W-1:0];
                end
                default: r.status = ST_BAD_COMMAND;
            endcase
        end
        return r;
    endfunction

    // mostly ticks on live channels, with starts to keep them breathing
    function automatic t_row random_row();
        logic [FUNC_W-1:0] f;
        logic [CHAN_W-1:0] c;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 58)      f = FN_TICK;
        else if (pick < 68) f = FN_START;
        else if (pick < 75) f = FN_TOGGLE;
        else if (pick < 81) f = FN_ON;
        else if (pick < 87) f = FN_OFF;
        else if (pick < 93) f = FUNC_W'($urandom_range(FN_RSVD_A, FN_RSVD_C));
        else                f = FN_TICK;
        if ($urandom_range(0, 9) == 0)
            c = CHAN_W'($urandom_range(NUM_CHANNELS, 15));
        else
            c = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
        return plain_row(f, c, START_W'($urandom_range(0, 255)));
    endfunction

    task automatic send_item(input t_row row);
        int      gap;
        t_result predicted;
        if ($urandom_range(0, 31) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.func <= row.cmd.func;
        item_ch.channel <= row.cmd.channel;
        item_ch.start_level <= row.cmd.start_level;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        predicted = breathe_step(row.cmd);
        duty_expect_q.push_back(row.typed ? row.want : predicted);
    endtask

    // only written once every pending result is back
    task automatic write_duty_scale(input logic [DUTY_W-1:0] value);
        while (duty_expect_q.size() != 0) @(posedge i_clk);
        i_max_duty_we <= 1'b1;
        i_max_duty_wdata <= value;
        @(posedge i_clk);
        i_max_duty_we <= 1'b0;
        duty_scale = value;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_max_duty_we = 1'b0;
        i_max_duty_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.func = FN_TICK;
        item_ch.channel = '0;
        item_ch.start_level = '0;
        n_errors = 0;
        duty_scale = MAX_DUTY_RESET;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            ch_level[i] = '0;
            ch_rising[i] = 1'b1;
            ch_running[i] = 1'b0;
        end
        phase_scale = '{16'hFFFF, 16'd0, DUTY_W'($urandom), 16'd1, DUTY_W'($urandom),
                        MAX_DUTY_RESET};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
            send_item(DIRECTED[i]);
        item_ch.valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_duty_scale(phase_scale[p]);
            repeat (ITEMS_PER_PHASE) send_item(random_row());
            item_ch.valid <= 1'b0;
        end

        while (duty_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        t_result got;
        t_result want;
        int      gap;
        result_ch.ready = 1'b0;
        n_results = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                recv_steady = !recv_steady;
            // one long hold-off so the pipeline backs up into the input
            if (n_results == HOLD_AFTER)
                gap = HOLD_CYCLES;
            else
                gap = recv_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_ch.valid) @(posedge i_clk);
            n_results++;
            got.out_channel = result_ch.out_channel;
            got.duty_write = result_ch.duty_write;
            got.duty = result_ch.duty;
            got.status = result_ch.status;
            if (duty_expect_q.size() == 0) begin
                $error("result item with none pending: channel %0d", got.out_channel);
                n_errors++;
            end else begin
                want = duty_expect_q.pop_front();
                if (got.out_channel !== want.out_channel) begin
                    $error("out_channel: expected %0d, got %0d",
                           want.out_channel, got.out_channel);
                    n_errors++;
                end
                if (got.duty_write !== want.duty_write) begin
                    $error("duty_write: expected %0d, got %0d",
                           want.duty_write, got.duty_write);
                    n_errors++;
                end
                if (got.duty !== want.duty) begin
                    $error("duty: expected %0d, got %0d", want.duty, got.duty);
                    n_errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial stall_cycles = 0;

endmodule

`default_nettype wire
